FILE: rtl/core/pcsp_pkg.sv
// Types, codes and constants shared by the PNG chunk stream parser.
`timescale 1ns / 1ps

package pcsp_pkg;

    // Input transaction: one file byte, or an end-of-stream marker.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } in_item_t;

    // Result transaction.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       payload_valid;
        logic [1:0] chunk_kind;
        logic       chunk_end;
        logic [1:0] status;
        logic       ihdr_seen;
        logic       idat_seen;
        logic       iend_seen;
    } out_item_t;

    typedef enum logic [2:0] {
        PH_SIG,
        PH_LEN,
        PH_TYPE,
        PH_PAY,
        PH_CRC
    } phase_t;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_IHDR  = 2'd1;
    localparam logic [1:0] KIND_IDAT  = 2'd2;
    localparam logic [1:0] KIND_IEND  = 2'd3;

    localparam logic [1:0] ST_RUNNING = 2'd0;
    localparam logic [1:0] ST_BAD_SIG = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;
    localparam logic [1:0] ST_CLEAN   = 2'd3;

    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    localparam logic [2:0] LAST_SIG_IDX = 3'd7;
    localparam logic [2:0] LAST_FIELD_IDX = 3'd3;

    // Expected byte of the file signature at each position.
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0: val = 8'h89;
            3'd1: val = 8'h50;
            3'd2: val = 8'h4E;
            3'd3: val = 8'h47;
            3'd4: val = 8'h0D;
            3'd5: val = 8'h0A;
            3'd6: val = 8'h1A;
            3'd7: val = 8'h0A;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

FILE: rtl/core/pcsp_walker.sv
// Chunk walker: parser state and the result for one byte or end marker.
`timescale 1ns / 1ps

module pcsp_walker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  pcsp_pkg::in_item_t  item,
    output pcsp_pkg::out_item_t result
);

    pcsp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] len_reg, len_next;
    logic [23:0] type_reg, type_next;
    logic [1:0]  kind_reg, kind_next;
    logic [2:0]  seen_reg, seen_next;
    logic [1:0]  err_reg, err_next;

    logic [31:0] type_full;
    logic        pay_valid;
    logic [1:0]  out_kind;
    logic        cend;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= pcsp_pkg::PH_SIG;
            cnt_reg   <= '0;
            len_reg   <= '0;
            type_reg  <= '0;
            kind_reg  <= pcsp_pkg::KIND_OTHER;
            seen_reg  <= '0;
            err_reg   <= pcsp_pkg::ST_RUNNING;
        end else if (step) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            type_reg  <= type_next;
            kind_reg  <= kind_next;
            seen_reg  <= seen_next;
            err_reg   <= err_next;
        end
    end

    assign type_full = {type_reg, item.data_byte};

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        type_next  = type_reg;
        kind_next  = kind_reg;
        seen_next  = seen_reg;
        err_next   = err_reg;
        pay_valid  = 1'b0;
        out_kind   = pcsp_pkg::KIND_OTHER;
        cend       = 1'b0;

        if (err_reg == pcsp_pkg::ST_RUNNING) begin
            if (item.stream_end) begin
                // A clean end is only possible where the next length field would start.
                if (phase_reg == pcsp_pkg::PH_LEN && cnt_reg == '0) begin
                    err_next = pcsp_pkg::ST_CLEAN;
                end else begin
                    err_next = pcsp_pkg::ST_TRUNC;
                end
            end else begin
                case (phase_reg)
                    pcsp_pkg::PH_SIG: begin
                        if (item.data_byte != pcsp_pkg::sig_byte(cnt_reg)) begin
                            err_next = pcsp_pkg::ST_BAD_SIG;
                        end else if (cnt_reg == pcsp_pkg::LAST_SIG_IDX) begin
                            phase_next = pcsp_pkg::PH_LEN;
                            cnt_next   = '0;
                        end else begin
                            cnt_next = cnt_reg + 3'd1;
                        end
                    end
                    pcsp_pkg::PH_LEN: begin
                        len_next = {len_reg[23:0], item.data_byte};
                        if (cnt_reg == pcsp_pkg::LAST_FIELD_IDX) begin
                            phase_next = pcsp_pkg::PH_TYPE;
                            cnt_next   = '0;
                        end else begin
                            cnt_next = cnt_reg + 3'd1;
                        end
                    end
                    pcsp_pkg::PH_TYPE: begin
                        type_next = {type_reg[15:0], item.data_byte};
                        if (cnt_reg == pcsp_pkg::LAST_FIELD_IDX) begin
                            if (type_full == pcsp_pkg::TYPE_IHDR) begin
                                kind_next    = pcsp_pkg::KIND_IHDR;
                                seen_next[0] = 1'b1;
                            end else if (type_full == pcsp_pkg::TYPE_IDAT) begin
                                kind_next    = pcsp_pkg::KIND_IDAT;
                                seen_next[1] = 1'b1;
                            end else if (type_full == pcsp_pkg::TYPE_IEND) begin
                                kind_next    = pcsp_pkg::KIND_IEND;
                                seen_next[2] = 1'b1;
                            end else begin
                                kind_next = pcsp_pkg::KIND_OTHER;
                            end
                            out_kind   = kind_next;
                            phase_next = (len_reg == '0) ? pcsp_pkg::PH_CRC : pcsp_pkg::PH_PAY;
                            cnt_next   = '0;
                        end else begin
                            cnt_next = cnt_reg + 3'd1;
                        end
                    end
                    pcsp_pkg::PH_PAY: begin
                        // The length register counts the payload bytes still to come.
                        pay_valid = 1'b1;
                        out_kind  = kind_reg;
                        len_next  = len_reg - 32'd1;
                        if (len_reg == 32'd1) begin
                            phase_next = pcsp_pkg::PH_CRC;
                        end
                    end
                    pcsp_pkg::PH_CRC: begin
                        out_kind = kind_reg;
                        if (cnt_reg == pcsp_pkg::LAST_FIELD_IDX) begin
                            cend       = 1'b1;
                            phase_next = pcsp_pkg::PH_LEN;
                            cnt_next   = '0;
                            len_next   = '0;
                        end else begin
                            cnt_next = cnt_reg + 3'd1;
                        end
                    end
                    default: begin
                        phase_next = pcsp_pkg::PH_SIG;
                    end
                endcase
            end
            if (err_next != pcsp_pkg::ST_RUNNING) begin
                pay_valid = 1'b0;
                out_kind  = pcsp_pkg::KIND_OTHER;
                cend      = 1'b0;
            end
        end

        result.out_byte      = item.stream_end ? 8'h00 : item.data_byte;
        result.payload_valid = pay_valid;
        result.chunk_kind    = out_kind;
        result.chunk_end     = cend;
        result.status        = err_next;
        result.ihdr_seen     = seen_next[0];
        result.idat_seen     = seen_next[1];
        result.iend_seen     = seen_next[2];
    end

    // Once the parser has stopped, its status never changes until reset.
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != pcsp_pkg::ST_RUNNING) |=> (err_reg == $past(err_reg)))
        else $error("pcsp_walker: terminal status changed");

    // Seen flags are only ever set.
    a_seen_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> ((seen_reg & $past(seen_reg)) == $past(seen_reg)))
        else $error("pcsp_walker: seen flag cleared");

    // The field counters never pass the last byte of their field.
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != pcsp_pkg::PH_SIG) |-> (cnt_reg <= pcsp_pkg::LAST_FIELD_IDX))
        else $error("pcsp_walker: field counter out of range");

    // Payload phase is never entered with nothing left to count.
    a_pay_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == pcsp_pkg::PH_PAY) |-> (len_reg != '0))
        else $error("pcsp_walker: payload phase with zero length");

endmodule

FILE: rtl/core/png_chunk_stream_parser.sv
// Top level of the PNG chunk stream parser: input register, walker and result register.
//
//  Channel  Ports                      Direction  Contents
//  s_       s_valid s_ready s_data     in         one file byte or an end-of-stream marker
//  m_       m_valid m_ready m_data     out        one result per input transaction
//
//  One transaction is taken every cycle while m_ready does not stall the result register;
//  an accepted input waits in the input register until its result moves to the result register.
//  The walker's phase and counter update handles one byte per cycle on the same condition.
//  aresetn is synchronous and active low; it clears the valid flags of both registers and the walker state.
//  A stalled m_ready holds the result register, then the input register, then s_ready.
`timescale 1ns / 1ps

module png_chunk_stream_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pcsp_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pcsp_pkg::out_item_t m_data
);

    logic                in_vld_reg, in_vld_next;
    pcsp_pkg::in_item_t  in_data_reg;
    logic                out_vld_reg, out_vld_next;
    pcsp_pkg::out_item_t out_data_reg;
    pcsp_pkg::out_item_t step_result;
    logic                advance;

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    pcsp_walker u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_data_reg),
        .result  (step_result)
    );

    always_comb begin
        in_vld_next  = in_vld_reg;
        out_vld_next = out_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
        if (advance) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

    // Backpressure only comes from a held input register.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && out_vld_reg && !m_ready))
        else $error("png_chunk_stream_parser: s_ready low without a stall");

    // Payload is never reported once the parser has stopped.
    a_pay_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.payload_valid) |-> (m_data.status == pcsp_pkg::ST_RUNNING))
        else $error("png_chunk_stream_parser: payload with terminal status");

    // A byte is either payload or the final CRC byte, never both.
    a_pay_cend: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.payload_valid && m_data.chunk_end))
        else $error("png_chunk_stream_parser: payload marked as chunk end");

    // Every accepted transaction reaches the result register on the next cycle it can move.
    a_advance_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("png_chunk_stream_parser: result lost");

endmodule
